/* rtl/ptc_pkg.sv */
// shared types and constants of the palette texel converter
package ptc_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int MAX_DIM       = 4096;

  localparam int PAL_AW    = $clog2(PALETTE_DEPTH);
  localparam int PAL_IDX_W = 8;
  localparam int ENTRY_W   = 18;
  localparam int COMP_W    = 6;
  localparam int CFG_DIM_W = 13;
  localparam int CNT_W     = $clog2(MAX_DIM);
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;

  localparam logic [PAL_IDX_W-1:0] TRANSPARENT_INDEX       = 8'd255;
  localparam logic [PAL_IDX_W-1:0] SUPER_TRANSPARENT_INDEX = 8'd254;

  localparam logic [7:0] KEY_RED   = 8'd120;
  localparam logic [7:0] KEY_GREEN = 8'd88;
  localparam logic [7:0] KEY_BLUE  = 8'd128;

  // ceil(2^16 / 10), exact for sums below 16384
  localparam logic [12:0] TENTH_RECIP = 13'd6554;

  typedef enum logic [2:0] {
    FMT_LUM      = 3'd0,
    FMT_LUM_A    = 3'd1,
    FMT_RGB888   = 3'd2,
    FMT_RGB565   = 3'd3,
    FMT_RGBA8888 = 3'd4,
    FMT_RGBA4444 = 3'd5
  } texel_fmt_e;

  typedef enum logic [1:0] {
    TM_OPAQUE     = 2'd0,
    TM_INTENSITY  = 2'd1,
    TM_INDEX_ZERO = 2'd2
  } transp_mode_e;

  typedef enum logic [2:0] {
    REG_TEXEL_FORMAT   = 3'd0,
    REG_TRANSP_MODE    = 3'd1,
    REG_SUPER_TRANSP   = 3'd2,
    REG_IMAGE_WIDTH    = 3'd3,
    REG_IMAGE_HEIGHT   = 3'd4,
    REG_TEXTURE_WIDTH  = 3'd5,
    REG_TEXTURE_HEIGHT = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic                 action;
    logic [PAL_IDX_W-1:0] color_index;
    logic [COMP_W-1:0]    red_in;
    logic [COMP_W-1:0]    green_in;
    logic [COMP_W-1:0]    blue_in;
  } texel_in_t;

  typedef struct packed {
    logic [31:0] texel_value;
    logic [2:0]  texel_bytes;
    logic        needs_alpha_format;
    logic        last_texel;
  } texel_out_t;

endpackage

/* rtl/ptc_ram.sv */
// generic single-write, single-read ram with registered read data
module ptc_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/palette_texel_converter.sv */
// palette texel converter: an accepted texel word is registered in stage s1, then in
// the output register; throughput one word per cycle while the output is not stalled;
// the palette ram's registered read sets the middle stage; palette writes give no result
// reset restores the register defaults and clears the counters, the alpha flag and valids
// palette contents are undefined until written
module palette_texel_converter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ptc_pkg::texel_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ptc_pkg::texel_out_t        out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ptc_pkg::CFG_AW-1:0] paddr,
  input  logic [ptc_pkg::CFG_DW-1:0] pwdata,
  output logic [ptc_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import ptc_pkg::*;

  typedef struct packed {
    logic                 oob;
    logic [PAL_IDX_W-1:0] cidx;
    logic                 transp;
    logic                 superk;
    texel_fmt_e           fmt;
    logic [1:0]           tmode;
    logic                 needs_alpha;
    logic                 last;
  } stage_t;

  // configuration registers
  logic [2:0]           texel_format_q;
  logic [1:0]           transp_mode_q;
  logic                 super_transp_q;
  logic [CFG_DIM_W-1:0] image_width_q, image_height_q;
  logic [CFG_DIM_W-1:0] texture_width_q, texture_height_q;

  logic                 cfg_we;
  cfg_reg_e             cfg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      texel_format_q   <= FMT_RGBA8888;
      transp_mode_q    <= TM_OPAQUE;
      super_transp_q   <= 1'b0;
      image_width_q    <= 13'd64;
      image_height_q   <= 13'd64;
      texture_width_q  <= 13'd64;
      texture_height_q <= 13'd64;
    end else if (cfg_we) begin
      case (cfg_sel)
        REG_TEXEL_FORMAT:   texel_format_q   <= pwdata[2:0];
        REG_TRANSP_MODE:    transp_mode_q    <= pwdata[1:0];
        REG_SUPER_TRANSP:   super_transp_q   <= pwdata[0];
        REG_IMAGE_WIDTH:    image_width_q    <= pwdata[CFG_DIM_W-1:0];
        REG_IMAGE_HEIGHT:   image_height_q   <= pwdata[CFG_DIM_W-1:0];
        REG_TEXTURE_WIDTH:  texture_width_q  <= pwdata[CFG_DIM_W-1:0];
        REG_TEXTURE_HEIGHT: texture_height_q <= pwdata[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_TEXEL_FORMAT:   prdata = {29'd0, texel_format_q};
      REG_TRANSP_MODE:    prdata = {30'd0, transp_mode_q};
      REG_SUPER_TRANSP:   prdata = {31'd0, super_transp_q};
      REG_IMAGE_WIDTH:    prdata = {19'd0, image_width_q};
      REG_IMAGE_HEIGHT:   prdata = {19'd0, image_height_q};
      REG_TEXTURE_WIDTH:  prdata = {19'd0, texture_width_q};
      REG_TEXTURE_HEIGHT: prdata = {19'd0, texture_height_q};
      default:            prdata = '0;
    endcase
  end

  // handshake
  logic       s1_valid_q, out_valid_q;
  stage_t     s1_q, s1_d;
  texel_out_t out_q, out_d;
  logic       out_adv, accept, conv_accept, pal_we;

  assign out_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = s1_valid_q && !out_adv;
  assign accept      = in_valid_i && !in_stall_o;
  assign conv_accept = accept && !in_data_i.action;
  assign pal_we      = accept && in_data_i.action
                       && ({1'b0, in_data_i.color_index} < (PAL_IDX_W+1)'(PALETTE_DEPTH));

  // raster position and index selection
  logic [CNT_W-1:0]     col_q, row_q, col_d, row_d;
  logic                 alpha_needed_q, alpha_needed_d;
  logic [CFG_DIM_W-1:0] tw, th, col_inc, row_inc;
  logic                 col_wrap, row_wrap, in_image;
  logic [PAL_IDX_W-1:0] cidx;
  logic                 transp, superk;
  texel_fmt_e           fmt;

  always_comb begin
    tw = texture_width_q;
    if (texture_width_q == '0) tw = CFG_DIM_W'(1);
    else if (texture_width_q > CFG_DIM_W'(MAX_DIM)) tw = CFG_DIM_W'(MAX_DIM);
    th = texture_height_q;
    if (texture_height_q == '0) th = CFG_DIM_W'(1);
    else if (texture_height_q > CFG_DIM_W'(MAX_DIM)) th = CFG_DIM_W'(MAX_DIM);

    col_inc  = {{(CFG_DIM_W-CNT_W){1'b0}}, col_q} + CFG_DIM_W'(1);
    row_inc  = {{(CFG_DIM_W-CNT_W){1'b0}}, row_q} + CFG_DIM_W'(1);
    col_wrap = col_inc >= tw;
    row_wrap = row_inc >= th;

    col_d = col_q;
    row_d = row_q;
    if (conv_accept) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_inc[CNT_W-1:0];
      end else begin
        col_d = col_inc[CNT_W-1:0];
      end
    end

    in_image = ({{(CFG_DIM_W-CNT_W){1'b0}}, col_q} < image_width_q)
               && ({{(CFG_DIM_W-CNT_W){1'b0}}, row_q} < image_height_q);
    cidx   = in_image ? in_data_i.color_index : TRANSPARENT_INDEX;
    transp = (transp_mode_q != TM_OPAQUE) && (cidx == TRANSPARENT_INDEX);
    superk = !transp && super_transp_q && (cidx == SUPER_TRANSPARENT_INDEX);

    // unused format codes act as rgba8888
    fmt = (texel_format_q > FMT_RGBA4444) ? FMT_RGBA8888 : texel_fmt_e'(texel_format_q);

    alpha_needed_d = alpha_needed_q;
    if (conv_accept && (fmt == FMT_RGB888 || fmt == FMT_RGB565) && (transp || superk)) begin
      alpha_needed_d = 1'b1;
    end

    s1_d.oob         = {1'b0, cidx} >= (PAL_IDX_W+1)'(PALETTE_DEPTH);
    s1_d.cidx        = cidx;
    s1_d.transp      = transp;
    s1_d.superk      = superk;
    s1_d.fmt         = fmt;
    s1_d.tmode       = transp_mode_q;
    s1_d.needs_alpha = alpha_needed_d;
    s1_d.last        = col_wrap && row_wrap;
  end

  // palette store
  logic [ENTRY_W-1:0] pal_rdata;

  ptc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (pal_we),
    .waddr_i(in_data_i.color_index[PAL_AW-1:0]),
    .wdata_i({in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in}),
    .re_i   (conv_accept),
    .raddr_i(cidx[PAL_AW-1:0]),
    .rdata_o(pal_rdata)
  );

  // texel packing
  logic [ENTRY_W-1:0] ent;
  logic [7:0]         r8, g8, b8, rr, gg, bb, aa;
  logic [11:0]        isum;
  logic [24:0]        iprod;

  always_comb begin
    ent   = s1_q.oob ? '0 : pal_rdata;
    r8    = {ent[17:12], 2'b00};
    g8    = {ent[11:6], 2'b00};
    b8    = {ent[5:0], 2'b00};
    isum  = 12'(3 * r8) + 12'(5 * g8) + 12'(2 * b8);
    iprod = {13'd0, isum} * {12'd0, TENTH_RECIP};

    rr = r8;
    gg = g8;
    bb = b8;
    priority if (s1_q.transp) begin
      rr = '0;
      gg = '0;
      bb = '0;
      aa = '0;
    end else if (s1_q.superk) begin
      rr = KEY_RED;
      gg = KEY_GREEN;
      bb = KEY_BLUE;
      aa = '0;
    end else if (s1_q.tmode == TM_INTENSITY) begin
      aa = iprod[23:16];
    end else if (s1_q.tmode == TM_INDEX_ZERO) begin
      aa = (s1_q.cidx != '0) ? 8'hff : 8'h00;
    end else begin
      aa = 8'hff;
    end

    out_d.needs_alpha_format = s1_q.needs_alpha;
    out_d.last_texel         = s1_q.last;
    case (s1_q.fmt)
      FMT_LUM: begin
        out_d.texel_value = s1_q.transp ? 32'd0 : 32'h0000_00ff;
        out_d.texel_bytes = 3'd1;
      end
      FMT_LUM_A: begin
        out_d.texel_value = s1_q.transp ? 32'd0 : 32'h0000_ffff;
        out_d.texel_bytes = 3'd2;
      end
      FMT_RGB888: begin
        out_d.texel_value = {8'd0, b8, g8, r8};
        out_d.texel_bytes = 3'd3;
      end
      FMT_RGB565: begin
        out_d.texel_value = {16'd0, b8[7:3], g8[7:2], r8[7:3]};
        out_d.texel_bytes = 3'd2;
      end
      FMT_RGBA4444: begin
        out_d.texel_value = {16'd0, aa[7:4], bb[7:4], gg[7:4], rr[7:4]};
        out_d.texel_bytes = 3'd2;
      end
      default: begin
        out_d.texel_value = {aa, bb, gg, rr};
        out_d.texel_bytes = 3'd4;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q          <= '0;
      row_q          <= '0;
      alpha_needed_q <= 1'b0;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      col_q          <= col_d;
      row_q          <= row_d;
      alpha_needed_q <= alpha_needed_d;
      if (conv_accept) s1_valid_q <= 1'b1;
      else if (out_adv) s1_valid_q <= 1'b0;
      if (out_adv) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (conv_accept) s1_q <= s1_d;
    if (out_adv && s1_valid_q) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_alpha_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alpha_needed_q |=> alpha_needed_q)
    else $error("alpha flag cleared");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with free stage");

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_accept && s1_d.last |=> col_q == '0 && row_q == '0)
    else $error("counters not wrapped after last texel");

endmodule
